// ----- sv/hdlc_dfr_pkg.sv -----
// ----------------------------------------------------------------------------
// HDLC deframer package
// Shared types, byte codes, queue sizes and the FCS-16 step function.
// ----------------------------------------------------------------------------
package hdlc_dfr_pkg;

    localparam int unsigned LEN_W     = 12;
    localparam int unsigned MAX_FRAME = 4095;

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ESC_XOR   = 8'h20;

    localparam logic [15:0] FCS_INIT  = 16'hFFFF;
    localparam logic [15:0] FCS_GOOD  = 16'hF0B8;
    localparam logic [15:0] FCS_POLY  = 16'h8408;

    // Result kinds.
    localparam logic [1:0]  KIND_DATA = 2'd0;
    localparam logic [1:0]  KIND_END  = 2'd1;
    localparam logic [1:0]  KIND_DROP = 2'd2;

    // Configuration register indexes.
    localparam logic        REG_MIN_LEN = 1'b0;
    localparam logic        REG_MAX_LEN = 1'b1;

    // Queue between the classifier and the frame engine.
    localparam int unsigned TOK_DEPTH = 4;
    localparam int unsigned TOK_PTR_W = $clog2(TOK_DEPTH);
    localparam int unsigned TOK_CNT_W = $clog2(TOK_DEPTH + 1);

    // Result queue at the output.
    localparam int unsigned RES_DEPTH = 4;
    localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
    localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

    // One classified line byte.
    typedef struct packed {
        logic       is_flag;
        logic       is_esc;
        logic [7:0] value;
    } tok_t;

    // One result word.
    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] frame_len;
        logic             crc_ok;
    } res_t;

    // PPP FCS-16 over one byte, LSB first.
    function automatic logic [15:0] fcs_update(input logic [15:0] fcs,
                                               input logic [7:0]  b);
        logic [15:0] f;
        f = fcs ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (f[0])
            begin
                f = (f >> 1) ^ FCS_POLY;
            end
            else
            begin
                f = f >> 1;
            end
        end
        return f;
    endfunction

endpackage

// ----- sv/hdlc_dfr_front.sv -----
// ----------------------------------------------------------------------------
// HDLC deframer front end
// Accepts raw line bytes, marks flags and escapes, and queues them.
// ----------------------------------------------------------------------------
module hdlc_dfr_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          rx_byte,
    output logic                tok_valid,
    output hdlc_dfr_pkg::tok_t  tok,
    input  logic                tok_take
);
    import hdlc_dfr_pkg::*;

    tok_t                 mem_reg [TOK_DEPTH];
    logic [TOK_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [TOK_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [TOK_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 do_push;
    logic                 do_pop;
    tok_t                 tok_in;

    always_comb
    begin
        tok_in.is_flag = (rx_byte == FLAG_BYTE);
        tok_in.is_esc  = (rx_byte == ESC_BYTE);
        tok_in.value   = rx_byte;

        full      = (cnt_reg == TOK_CNT_W'(TOK_DEPTH));
        tok_valid = (cnt_reg != '0);
        tok       = mem_reg[rd_ptr_reg];

        do_push = push && !full;
        do_pop  = tok_valid && tok_take;

        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= tok_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- sv/hdlc_dfr_back.sv -----
// ----------------------------------------------------------------------------
// HDLC deframer back end
// Runs the frame state machine, FCS and delay line, and queues results.
// ----------------------------------------------------------------------------
module hdlc_dfr_back
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                tok_valid,
    input  hdlc_dfr_pkg::tok_t                  tok,
    output logic                                tok_take,
    input  logic [hdlc_dfr_pkg::LEN_W-1:0]      min_len,
    input  logic [hdlc_dfr_pkg::LEN_W-1:0]      max_len,
    output logic                                empty,
    input  logic                                pop,
    output hdlc_dfr_pkg::res_t                  res
);
    import hdlc_dfr_pkg::*;

    localparam logic [1:0] PH_HUNT  = 2'd0;
    localparam logic [1:0] PH_FRAME = 2'd1;
    localparam logic [1:0] PH_ESC   = 2'd2;

    logic [1:0]       phase_reg, phase_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic [15:0]      fcs_reg, fcs_next;
    logic [7:0]       dly0_reg, dly0_next;
    logic [7:0]       dly1_reg, dly1_next;

    res_t                 mem_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 res_full;
    logic                 do_push;
    logic                 do_pop;

    logic             gen_valid;
    res_t             gen_res;
    logic [LEN_W-1:0] limit;
    logic [LEN_W-1:0] need;
    logic [7:0]       sbyte;
    logic             store;

    always_comb
    begin
        limit = (max_len > LEN_W'(MAX_FRAME)) ? LEN_W'(MAX_FRAME) : max_len;
        need  = (min_len < LEN_W'(2)) ? LEN_W'(2) : min_len;

        phase_next = phase_reg;
        count_next = count_reg;
        fcs_next   = fcs_reg;
        dly0_next  = dly0_reg;
        dly1_next  = dly1_reg;
        gen_valid  = 1'b0;
        gen_res    = '0;
        store      = 1'b0;
        sbyte      = tok.value;

        case (phase_reg)
            PH_FRAME:
            begin
                if (tok.is_esc)
                begin
                    phase_next = PH_ESC;
                end
                else if (tok.is_flag)
                begin
                    phase_next = PH_HUNT;
                    count_next = '0;
                    gen_valid  = 1'b1;
                    if (count_reg < need)
                    begin
                        gen_res.kind = KIND_DROP;
                    end
                    else
                    begin
                        gen_res.kind      = KIND_END;
                        gen_res.frame_len = count_reg - LEN_W'(2);
                        gen_res.crc_ok    = (fcs_reg == FCS_GOOD);
                    end
                end
                else
                begin
                    store = 1'b1;
                end
            end
            PH_ESC:
            begin
                if (tok.is_esc || tok.is_flag)
                begin
                    phase_next   = PH_HUNT;
                    count_next   = '0;
                    gen_valid    = 1'b1;
                    gen_res.kind = KIND_DROP;
                end
                else
                begin
                    store = 1'b1;
                    sbyte = tok.value ^ ESC_XOR;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
                if (tok.is_flag)
                begin
                    phase_next = PH_FRAME;
                    count_next = '0;
                    fcs_next   = FCS_INIT;
                    dly0_next  = '0;
                    dly1_next  = '0;
                end
            end
        endcase

        if (store)
        begin
            if (count_reg >= limit)
            begin
                // Frame too long: drop this byte and the frame.
                phase_next   = PH_HUNT;
                count_next   = '0;
                gen_valid    = 1'b1;
                gen_res.kind = KIND_DROP;
            end
            else
            begin
                fcs_next   = fcs_update(fcs_reg, sbyte);
                dly0_next  = dly1_reg;
                dly1_next  = sbyte;
                count_next = count_reg + 1'b1;
                phase_next = PH_FRAME;
                if (count_reg >= LEN_W'(2))
                begin
                    gen_valid         = 1'b1;
                    gen_res.kind      = KIND_DATA;
                    gen_res.data_byte = dly0_reg;
                end
            end
        end
    end

    // Result queue.
    always_comb
    begin
        res_full = (cnt_reg == RES_CNT_W'(RES_DEPTH));
        empty    = (cnt_reg == '0);
        res      = mem_reg[rd_ptr_reg];
        tok_take = tok_valid && !res_full;

        do_push = tok_take && gen_valid;
        do_pop  = pop && !empty;

        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= gen_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            count_reg  <= '0;
            fcs_reg    <= FCS_INIT;
            dly0_reg   <= '0;
            dly1_reg   <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (tok_take)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                fcs_reg   <= fcs_next;
                dly0_reg  <= dly0_next;
                dly1_reg  <= dly1_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- sv/hdlc_deframer_with_fcs16_check_top.sv -----
// ----------------------------------------------------------------------------
// HDLC deframer with FCS-16 check
// Removes flags and byte stuffing from a PPP/HDLC line stream, holds back the
// FCS, and reports payload bytes and a frame end or discard per frame.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake          Payload
//   -------   ----------------   ----------------------------------------
//   input     push / full        rx_byte
//   result    empty / pop        kind, data_byte, frame_len, crc_ok
//   config    cfg_we             cfg_addr (0 min_len, 1 max_len), cfg_wdata
//
// The block takes one line word per clock cycle while full is low. A word is
// written into a four-entry word queue, is handled combinationally by the frame
// engine as it leaves that queue, and any result it makes is written into a
// four-entry result queue, from which it can be popped.
// Reset returns the engine to flag hunting with an empty delay line, empties
// both queues, and sets min_len to 2 and max_len to 4095.
// When the result queue fills, the engine stops taking words; the word queue
// keeps absorbing input until it fills too, and only then is full raised.
//
module hdlc_deframer_with_fcs16_check_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     rx_byte,
    output logic                           empty,
    input  logic                           pop,
    output logic [1:0]                     kind,
    output logic [7:0]                     data_byte,
    output logic [hdlc_dfr_pkg::LEN_W-1:0] frame_len,
    output logic                           crc_ok,
    input  logic                           cfg_we,
    input  logic                           cfg_addr,
    input  logic [hdlc_dfr_pkg::LEN_W-1:0] cfg_wdata
);
    import hdlc_dfr_pkg::*;

    // Configuration registers; the user must write them only while the block is idle (not enforced).
    logic [LEN_W-1:0] min_len_reg, min_len_next;
    logic [LEN_W-1:0] max_len_reg, max_len_next;

    logic tok_valid;
    tok_t tok;
    logic tok_take;
    res_t res;

    always_comb
    begin
        min_len_next = min_len_reg;
        max_len_next = max_len_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_MIN_LEN: min_len_next = cfg_wdata;
                REG_MAX_LEN: max_len_next = cfg_wdata;
                default:     min_len_next = min_len_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= LEN_W'(2);
            max_len_reg <= LEN_W'(4095);
        end
        else
        begin
            min_len_reg <= min_len_next;
            max_len_reg <= max_len_next;
        end
    end

    // The front end marks flag and escape words and queues every word.
    hdlc_dfr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .rx_byte   (rx_byte),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_take  (tok_take)
    );

    // The back end runs the frame state, FCS and two-word delay line.
    hdlc_dfr_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_take  (tok_take),
        .min_len   (min_len_reg),
        .max_len   (max_len_reg),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    assign kind      = res.kind;
    assign data_byte = res.data_byte;
    assign frame_len = res.frame_len;
    assign crc_ok    = res.crc_ok;

endmodule
